[design/srm_pkg.sv]
`timescale 1ns / 1ps

package srm_pkg;

  localparam int CmdBitsDefault    = 25;
  localparam int StatusBitsDefault = 9;

  localparam logic [31:0] WriteCmd = 32'h01FF_0002;
  localparam logic [31:0] ReadCmd  = 32'h01FF_8002;

  localparam logic [15:0] TicksPerPhaseReset = 16'd20;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] reg_address;
    logic [7:0] write_data;
    logic       sdo_level;
  } in_item_t;

  typedef struct packed {
    logic       clock_pin;
    logic       data_pin;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       status_error;
  } out_item_t;

endpackage

[design/srm_if.sv]
`timescale 1ns / 1ps

interface srm_in_if import srm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface srm_out_if import srm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[design/serial_register_access_master_unit.sv]
`timescale 1ns / 1ps

// Channel   Dir   Payload                                        Transaction
// in_if     in    func, reg_address, write_data, sdo_level      valid & ready
// out_if    out   clock_pin, data_pin, busy_res, done_res,      valid & ready
//                 read_value, status_error
// cfg       in    cfg_wdata_i (ticks_per_phase)                  cfg_we_i
//
// One transaction in gives one transaction out; a new tick is taken every cycle while in_if.ready is high.
// The sequencer state and the result register update in the cycle the tick is taken.
// in_if.ready is low only while a result sits in the output register and is not taken.
// Reset (rst_ni, async low): idle, pins high, ticks_per_phase = 20.

module serial_register_access_master_unit
  import srm_pkg::*;
#(
  parameter int CMD_BITS    = CmdBitsDefault,
  parameter int STATUS_BITS = StatusBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  srm_in_if.sink      in_if,
  srm_out_if.source   out_if
);

  localparam int NBits    = CMD_BITS + 16;
  localparam int IdxShift = 6;
  localparam int IdxQ     = IdxShift + 3 * NBits;
  localparam int IdxR     = IdxQ + 2;
  localparam int IdxStat  = IdxR + 6;
  localparam int IdxData  = IdxStat + 3 * STATUS_BITS;
  localparam int IdxTrail = IdxData + 24;
  localparam int IdxLast  = IdxTrail + 9;
  localparam int PhW      = $clog2(IdxLast + 1);

  typedef logic [PhW-1:0] phase_t;

  localparam phase_t PhIdle     = phase_t'(0);
  localparam phase_t PhFirst    = phase_t'(1);
  localparam phase_t PhDataLow  = phase_t'(2);
  localparam phase_t PhPulseHiA = phase_t'(3);
  localparam phase_t PhPulseLo  = phase_t'(4);
  localparam phase_t PhPulseHiB = phase_t'(5);
  localparam phase_t PhShift    = phase_t'(IdxShift);
  localparam phase_t PhQ        = phase_t'(IdxQ);
  localparam phase_t PhQ1       = phase_t'(IdxQ + 1);
  localparam phase_t PhQ2       = phase_t'(IdxQ + 2);
  localparam phase_t PhR        = phase_t'(IdxR);
  localparam phase_t PhStat     = phase_t'(IdxStat);
  localparam phase_t PhData     = phase_t'(IdxData);
  localparam phase_t PhDataEnd  = phase_t'(IdxData - 1);
  localparam phase_t PhTrail    = phase_t'(IdxTrail);
  localparam phase_t PhTrailHi  = phase_t'(IdxTrail + 8);
  localparam phase_t PhLast     = phase_t'(IdxLast);

  localparam logic [1:0] SubLow    = 2'd0;
  localparam logic [1:0] SubAction = 2'd1;
  localparam logic [1:0] SubEnd    = 2'd2;

  localparam logic [STATUS_BITS-1:0] StatAllOnes = '1;

  logic [15:0]            tpp_q;
  phase_t                 phase_q, phase_d;
  logic [15:0]            ticks_q, ticks_d;
  logic [1:0]             sub_q, sub_d;
  logic [NBits-1:0]       out_shift_q, out_shift_d;
  logic                   read_mode_q, read_mode_d;
  logic [STATUS_BITS-1:0] status_q, status_d;
  logic [7:0]             in_shift_q, in_shift_d;
  logic                   clock_q, clock_d;
  logic                   data_q, data_d;
  logic                   out_valid_q;
  out_item_t              out_item_q, out_item_d;

  logic                   accept;
  logic [15:0]            limit;
  phase_t                 nxt;
  logic [1:0]             sub_nxt;
  logic                   done;
  logic                   abort;
  logic [STATUS_BITS:0]   stat_cat;
  logic [31:0]            cmd_word;

  assign in_if.ready  = !out_valid_q || out_if.ready;
  assign accept       = in_if.valid && in_if.ready;
  assign out_if.valid = out_valid_q;
  assign out_if.payload = out_item_q;

  assign limit    = (tpp_q == 16'd0) ? 16'd1 : tpp_q;
  assign stat_cat = {status_q, in_if.payload.sdo_level};
  assign cmd_word = (in_if.payload.func == FUNC_READ) ? ReadCmd : WriteCmd;
  assign abort    = read_mode_q && (phase_q == PhDataEnd) && (status_q != StatAllOnes);

  // next phase, skipping the write-only and read-only steps
  always_comb begin
    nxt = phase_q + phase_t'(1);
    if (read_mode_q && nxt == PhQ) begin
      nxt = PhQ1;
    end else if (!read_mode_q && nxt == PhQ2) begin
      nxt = PhTrail;
    end
    if (nxt == PhShift || nxt == PhStat) begin
      sub_nxt = SubLow;
    end else begin
      sub_nxt = (sub_q == SubEnd) ? SubLow : sub_q + 2'd1;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    ticks_d     = ticks_q;
    sub_d       = sub_q;
    out_shift_d = out_shift_q;
    read_mode_d = read_mode_q;
    status_d    = status_q;
    in_shift_d  = in_shift_q;
    clock_d     = clock_q;
    data_d      = data_q;
    done        = 1'b0;

    if (accept) begin
      if (phase_q == PhIdle) begin
        if (in_if.payload.func == FUNC_WRITE || in_if.payload.func == FUNC_READ) begin
          read_mode_d = (in_if.payload.func == FUNC_READ);
          out_shift_d = {cmd_word[CMD_BITS-1:0], in_if.payload.reg_address,
                         (in_if.payload.func == FUNC_READ) ? 8'd0
                                                           : in_if.payload.write_data};
          status_d    = '0;
          in_shift_d  = '0;
          phase_d     = PhFirst;
          clock_d     = 1'b0;
          ticks_d     = 16'd1;
        end
      end else if (ticks_q < limit) begin
        ticks_d = ticks_q + 16'd1;
      end else if (abort || phase_q >= PhLast) begin
        phase_d = PhIdle;
        ticks_d = 16'd0;
        done    = 1'b1;
      end else begin
        phase_d = nxt;
        sub_d   = sub_nxt;
        ticks_d = 16'd1;
        if (nxt == PhFirst || nxt == PhPulseLo) begin
          clock_d = 1'b0;
        end else if (nxt == PhDataLow) begin
          data_d = 1'b0;
        end else if (nxt == PhPulseHiA || nxt == PhPulseHiB) begin
          clock_d = 1'b1;
        end else if (nxt >= PhShift && nxt < PhQ) begin
          case (sub_nxt)
            SubLow:    clock_d = 1'b0;
            SubAction: begin
              data_d      = out_shift_q[NBits-1];
              out_shift_d = {out_shift_q[NBits-2:0], 1'b0};
            end
            default:   clock_d = 1'b1;
          endcase
        end else if (nxt == PhQ) begin
          clock_d = 1'b0;
        end else if (nxt == PhQ1) begin
          clock_d = 1'b0;
          data_d  = 1'b0;
        end else if (nxt >= PhR && nxt < PhStat) begin
          clock_d = (nxt[0] == PhR[0]);
        end else if (nxt >= PhStat && nxt < PhData) begin
          case (sub_nxt)
            SubLow:    clock_d = 1'b1;
            SubAction: status_d = stat_cat[STATUS_BITS-1:0];
            default:   clock_d = 1'b0;
          endcase
        end else if (nxt >= PhData && nxt < PhTrail) begin
          case (sub_nxt)
            SubLow:    clock_d = 1'b1;
            SubAction: in_shift_d = {in_shift_q[6:0], in_if.payload.sdo_level};
            default:   clock_d = 1'b0;
          endcase
        end else if (nxt >= PhTrail && nxt < PhTrailHi) begin
          clock_d = (nxt[0] == PhTrail[0]);
        end else if (nxt == PhTrailHi) begin
          clock_d = 1'b1;
        end else if (nxt == PhLast) begin
          data_d = 1'b1;
        end
      end
    end

    out_item_d.clock_pin    = clock_d;
    out_item_d.data_pin     = data_d;
    out_item_d.busy_res     = (phase_d != PhIdle);
    out_item_d.done_res     = done;
    out_item_d.status_error = done && read_mode_q && (status_q != StatAllOnes);
    out_item_d.read_value   = (done && read_mode_q && status_q == StatAllOnes)
                              ? in_shift_q : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpp_q       <= TicksPerPhaseReset;
      phase_q     <= PhIdle;
      ticks_q     <= '0;
      sub_q       <= SubLow;
      out_shift_q <= '0;
      read_mode_q <= 1'b0;
      status_q    <= '0;
      in_shift_q  <= '0;
      clock_q     <= 1'b1;
      data_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tpp_q <= cfg_wdata_i;
      end
      phase_q     <= phase_d;
      ticks_q     <= ticks_d;
      sub_q       <= sub_d;
      out_shift_q <= out_shift_d;
      read_mode_q <= read_mode_d;
      status_q    <= status_d;
      in_shift_q  <= in_shift_d;
      clock_q     <= clock_d;
      data_q      <= data_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= out_item_d;
    end
  end

  // idle sequencer never holds a tick count
  a_idle_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhIdle |-> ticks_q == 16'd0)
    else $error("tick count nonzero while idle");

  // a finished frame reports idle in the same result
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.done_res |-> !out_item_q.busy_res)
    else $error("done reported while busy");

  // error and read data only on a done result, never both
  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_item_q.status_error || out_item_q.read_value != 8'd0)
      |-> out_item_q.done_res && !(out_item_q.status_error && out_item_q.read_value != 8'd0))
    else $error("status or read value outside a done result");

  // busy ticks always leave a running count
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q != PhIdle && ticks_q < limit |=> ticks_q == $past(ticks_q) + 16'd1)
    else $error("phase tick count did not advance");

endmodule
